### rtl/isq_pkg.sv
// Shared types and constants for the integer square root core.
`timescale 1ns / 1ps

package isq_pkg;

  localparam int ROOT_W = 16;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_RUN,
    ST_DONE
  } isq_state_t;

  typedef struct packed {
    logic load;
    logic step;
    logic capture;
  } isq_cmd_t;

endpackage

### rtl/isq_dp.sv
// Datapath: digit-by-digit square root, one root bit per step, plus result register.
`timescale 1ns / 1ps

module isq_dp import isq_pkg::*; #(
  parameter int VALUE_BITS = 31
) (
  input  logic                  clk,
  input  isq_cmd_t              cmd,
  input  logic [VALUE_BITS-1:0] value_i,
  output logic [ROOT_W-1:0]     root_o
);

  localparam int RB = (VALUE_BITS + 1) / 2;
  localparam int XP = 2 * RB;

  logic [XP-1:0]   x_r;
  logic [RB:0]     rem_r;
  logic [RB-1:0]   root_r;
  logic [ROOT_W-1:0] out_root_r;

  logic [RB+2:0]   rem_sh;
  logic [RB+2:0]   trial;
  logic [RB+2:0]   diff;
  logic            ge;

  // remainder stays at most twice the partial root, so RB+1 bits hold it
  assign rem_sh = {rem_r, x_r[XP-1 -: 2]};
  assign trial  = (RB+3)'({root_r, 2'b01});
  assign ge     = (rem_sh >= trial);
  assign diff   = rem_sh - trial;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      x_r    <= XP'(value_i);
      rem_r  <= '0;
      root_r <= '0;
    end else if (cmd.step) begin
      x_r    <= x_r << 2;
      rem_r  <= ge ? diff[RB:0] : rem_sh[RB:0];
      root_r <= (root_r << 1) | RB'(ge);
    end
    if (cmd.capture) begin
      out_root_r <= ROOT_W'(root_r);
    end
  end

  assign root_o = out_root_r;

endmodule

### rtl/isq_ctrl.sv
// Controller: sequences load, iteration steps and result hand-off.
`timescale 1ns / 1ps

module isq_ctrl import isq_pkg::*; #(
  parameter int VALUE_BITS = 31
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  output isq_cmd_t cmd
);

  localparam int RB  = (VALUE_BITS + 1) / 2;
  localparam int CW  = (RB > 1) ? $clog2(RB) : 1;
  localparam logic [CW-1:0] LAST = CW'(RB - 1);

  isq_state_t    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic          slot_free;

  assign slot_free = !out_valid_r || out_ready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_valid)          state_nxt = ST_RUN;
      ST_RUN:  if (cnt_r == LAST)     state_nxt = ST_DONE;
      ST_DONE: if (slot_free)         state_nxt = ST_IDLE;
      default:                        state_nxt = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd         = '0;
    in_ready    = 1'b0;
    cnt_nxt     = cnt_r;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
        cnt_nxt  = '0;
      end
      ST_RUN: begin
        cmd.step = 1'b1;
        cnt_nxt  = cnt_r + 1'b1;
      end
      ST_DONE: begin
        cmd.capture = slot_free;
      end
      default: begin
        cmd = '0;
      end
    endcase
    out_valid_nxt = cmd.capture ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

### rtl/integer_square_root_core.sv
// Top level: floor square root of one unsigned value per request.
//
//  channel | dir | tdata fields (low bit up)       | handshake
//  in_     | in  | value[VALUE_BITS-1:0], zero pad  | tvalid/tready
//  out_    | out | root[15:0]                       | tvalid/tready
//
// A request runs as one load, one iteration per root bit in the shared
// subtract/compare unit, and a move of the root into the output register.
// The next request is taken while a finished root waits in the output register.
// Reset (rst_n low, synchronous) clears the controller and the output valid.
// A stalled output holds the finished root in the datapath until the register frees.
`timescale 1ns / 1ps

module integer_square_root_core import isq_pkg::*; #(
  parameter int VALUE_BITS = 31
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [((VALUE_BITS + 7) / 8) * 8-1:0] in_tdata,   // value
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [ROOT_W-1:0]                     out_tdata   // root
);

  isq_cmd_t cmd;

  isq_ctrl #(
    .VALUE_BITS(VALUE_BITS)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_tvalid),
    .in_ready (in_tready),
    .out_valid(out_tvalid),
    .out_ready(out_tready),
    .cmd      (cmd)
  );

  isq_dp #(
    .VALUE_BITS(VALUE_BITS)
  ) u_dp (
    .clk    (clk),
    .cmd    (cmd),
    .value_i(in_tdata[VALUE_BITS-1:0]),
    .root_o (out_tdata)
  );

endmodule
